>>> sv/afws_pkg.sv
// shared types and constants of the adaptive fetch window scheduler
`default_nettype none

package afws_pkg;

   localparam int RATE_FRAC_BITS_DEF = 8;
   localparam logic [19:0] RATE_SCALE = 20'd1000000;

   localparam logic [31:0] DECISION_LENGTH_RST = 32'd1000;
   localparam logic [31:0] RECALC_LIMIT_RST    = 32'd10000;
   localparam logic [7:0]  WINDOW_MAX_RST      = 8'd128;
   localparam logic [7:0]  WINDOW_RST          = 8'd64;
   localparam logic [7:0]  STEP_RST            = 8'd16;

   localparam int DIV_W = 64;

   typedef enum logic [1:0] {
      CMD_EXEC   = 2'd0,
      CMD_FETCH  = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_code_type;

   typedef enum logic [1:0] {
      CSR_DECISION_LENGTH = 2'd0,
      CSR_RECALC_LIMIT    = 2'd1,
      CSR_WINDOW_MAX      = 2'd2,
      CSR_NONE            = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_SETTLE = 2'd0,
      PH_LOCAL  = 2'd1,
      PH_REMOTE = 2'd2,
      PH_RUN    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      DIV_RATE  = 2'd0,
      DIV_AVG_A = 2'd1,
      DIV_AVG_B = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RMUL,
      S_RSTART,
      S_RDIV,
      S_RUPD,
      S_ADV,
      S_AVGA,
      S_AVGB,
      S_PART,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic        latch;
      logic        mul;
      logic        div_start;
      div_sel_type div_sel;
      logic        rate_upd;
      logic        avg_a_wr;
      logic        avg_b_wr;
      logic        adv;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic recalc_go;
      logic adv_go;
      logic measure_phase;
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

>>> sv/adaptive_fetch_window_scheduler.sv
// a sample or plain tick goes from idle straight to the finish state; a window recalculation
// runs one division and a measure phase advance runs two, both on the shared divider
// throughput: one beat at a time; the shared bit-serial divider sets the long cases
// a finished result waits in the output register while the next beat is taken
// reset: synchronous, active high; window 64, step 16, phase 0, partitioned set
`default_nettype none

module adaptive_fetch_window_scheduler #(
   parameter int RATE_FRAC_BITS = afws_pkg::RATE_FRAC_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [143:0] req_tdata,  // duration[47:0], clock_now[111:48], committed_count[143:112]
   input  wire logic [1:0]   req_tuser,  // cmd[1:0]
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [23:0]  rsp_tdata,  // window_len[7:0], window_step[15:8], partitioned[16], phase[18:17]
   input  wire logic         csr_valid,
   output      logic         csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   afws_pkg::dp_cmd_type    cmd;
   afws_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   afws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   afws_dp #(
      .RATE_FRAC_BITS (RATE_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> sv/afws_div.sv
// iterative unsigned 64 by 64 divider, one quotient bit per cycle
`default_nettype none

module afws_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [afws_pkg::DIV_W-1:0] dividend,
   input  wire logic [afws_pkg::DIV_W-1:0] divisor,
   output      logic                     done,
   output      logic [afws_pkg::DIV_W-1:0] quotient
);

   localparam int W = afws_pkg::DIV_W;
   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [W:0]    rem_sh;
   logic [W:0]    rem_diff;
   logic          fits;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[W-1]};
      rem_diff = rem_sh - {1'b0, dvs_ff};
      fits     = rem_sh >= {1'b0, dvs_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? rem_diff[W-1:0] : rem_sh[W-1:0];
         quo_in   = {quo_ff[W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> sv/afws_dp.sv
// datapath: configuration, sums, throughput, window climb, phase cycle, result register
`default_nettype none

module afws_dp #(
   parameter int RATE_FRAC_BITS = afws_pkg::RATE_FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire afws_pkg::dp_cmd_type     cmd,
   output      afws_pkg::dp_status_type  status,
   input  wire logic [1:0]               req_tuser,
   input  wire logic [143:0]             req_tdata,
   input  wire logic                     csr_valid,
   input  wire logic [1:0]               csr_index,
   input  wire logic [31:0]              csr_data,
   output      logic [23:0]              rsp_tdata
);

   localparam logic [19:0] RATE_SCALE_W = afws_pkg::RATE_SCALE;

   logic [31:0] dl_ff, dl_in;
   logic [31:0] rl_ff, rl_in;
   logic [7:0]  wmax_ff, wmax_in;

   logic [7:0]  window_ff, window_in;
   logic [7:0]  step_ff, step_in;
   logic [31:0] tick_ff, tick_in;
   logic [63:0] last_clock_ff, last_clock_in;
   logic [31:0] last_comm_ff, last_comm_in;
   logic [63:0] last_rate_ff, last_rate_in;
   logic [1:0]  phase_ff, phase_in;
   logic        part_ff, part_in;
   logic [63:0] sums_ff [4];
   logic [63:0] sums_in [4];
   logic [31:0] counts_ff [4];
   logic [31:0] counts_in [4];
   logic [63:0] avgs_ff [4];
   logic [63:0] avgs_in [4];

   logic [63:0] clk_ff, clk_in;
   logic [31:0] comm_ff, comm_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] dclk_ff, dclk_in;
   logic [18:0] out_ff, out_in;

   logic [1:0]  in_cmd;
   logic [47:0] in_dur;
   logic [1:0]  samp_idx;
   logic [1:0]  ia, ib, isel;
   logic [31:0] comm_diff;
   logic [51:0] prod;
   logic [63:0] div_a, div_b;
   logic        div_done;
   logic [63:0] quo;
   logic [63:0] rate;
   logic [63:0] avg_a_val, avg_b_val;
   logic signed [9:0] s_old, s_grow, s_half, s_hh, s_new, w_sum;
   logic [64:0] sum_r, sum_l;
   logic [31:0] tick_inc;

   assign in_cmd = req_tuser;
   assign in_dur = req_tdata[47:0];
   assign tick_inc = tick_ff + 32'd1;
   assign ia = {1'b0, phase_ff[1]};
   assign ib = {1'b1, phase_ff[1]};
   assign isel = (cmd.div_sel == afws_pkg::DIV_AVG_B) ? ib : ia;
   assign samp_idx = {in_cmd == afws_pkg::CMD_FETCH, phase_ff == afws_pkg::PH_REMOTE};

   always_comb begin
      status.recalc_go     = tick_ff > rl_ff;
      status.adv_go        = tick_inc > dl_ff;
      status.measure_phase = (phase_ff == afws_pkg::PH_LOCAL) ||
                             (phase_ff == afws_pkg::PH_REMOTE);
      status.div_done      = div_done;
   end

   // divider operands
   always_comb begin
      if (cmd.div_sel == afws_pkg::DIV_RATE) begin
         div_a = num_ff;
         div_b = dclk_ff;
      end else begin
         div_a = sums_ff[isel];
         div_b = {32'd0, counts_ff[isel]};
      end
   end

   afws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (quo)
   );

   assign comm_diff = comm_ff - last_comm_ff;
   assign prod      = comm_diff * RATE_SCALE_W;

   always_comb begin
      rate = quo;
      if (dclk_ff == 64'd0) begin
         rate = (num_ff != 64'd0) ? '1 : '0;
      end
      avg_a_val = (counts_ff[ia] == 32'd0) ? 64'd0 : quo;
      avg_b_val = (counts_ff[ib] == 32'd0) ? 64'd0 : quo;
   end

   // hill climb on the step, then clamp the window
   always_comb begin
      s_old  = $signed({{2{step_ff[7]}}, step_ff});
      s_grow = (s_old >= 10'sd32 || s_old <= -10'sd32) ? s_old : (s_old <<< 1);
      s_half = s_old >>> 1;
      s_hh   = (s_old <= 10'sd4 && s_old >= -10'sd4) ? (s_half <<< 1) : s_half;
      s_new  = (rate > last_rate_ff) ? s_grow : -s_hh;
      w_sum  = $signed({2'b00, window_ff}) + s_new;
   end

   always_comb begin
      sum_r = {1'b0, avgs_ff[1]} + {1'b0, avgs_ff[3]};
      sum_l = {1'b0, avgs_ff[2]} + {1'b0, avgs_ff[0]};
   end

   always_comb begin
      dl_in         = dl_ff;
      rl_in         = rl_ff;
      wmax_in       = wmax_ff;
      window_in     = window_ff;
      step_in       = step_ff;
      tick_in       = tick_ff;
      last_clock_in = last_clock_ff;
      last_comm_in  = last_comm_ff;
      last_rate_in  = last_rate_ff;
      phase_in      = phase_ff;
      part_in       = part_ff;
      sums_in       = sums_ff;
      counts_in     = counts_ff;
      avgs_in       = avgs_ff;
      clk_in        = clk_ff;
      comm_in       = comm_ff;
      num_in        = num_ff;
      dclk_in       = dclk_ff;
      out_in        = out_ff;

      if (csr_valid) begin
         unique case (csr_index)
            afws_pkg::CSR_DECISION_LENGTH: dl_in   = csr_data;
            afws_pkg::CSR_RECALC_LIMIT:    rl_in   = csr_data;
            afws_pkg::CSR_WINDOW_MAX:      wmax_in = csr_data[7:0];
            default: ;
         endcase
      end

      if (cmd.latch) begin
         clk_in  = req_tdata[111:48];
         comm_in = req_tdata[143:112];
         if (in_cmd == afws_pkg::CMD_TICK) begin
            tick_in = tick_inc;
         end else if ((in_cmd == afws_pkg::CMD_EXEC || in_cmd == afws_pkg::CMD_FETCH) &&
                      status.measure_phase) begin
            for (int i = 0; i < 4; i++) begin
               if (samp_idx == 2'(i)) begin
                  sums_in[i]   = sums_ff[i] + {16'd0, in_dur};
                  counts_in[i] = counts_ff[i] + 32'd1;
               end
            end
         end
      end

      if (cmd.mul) begin
         num_in  = {12'd0, prod} << RATE_FRAC_BITS;
         dclk_in = clk_ff - last_clock_ff;
      end

      if (cmd.rate_upd) begin
         if (last_rate_ff != 64'd0) begin
            if (w_sum > 10'sd0) begin
               window_in = (w_sum > $signed({2'b00, wmax_ff})) ? wmax_ff : w_sum[7:0];
               step_in   = s_new[7:0];
            end else begin
               window_in = 8'd0;
               step_in   = 8'hFF;
            end
         end
         last_rate_in  = rate;
         last_clock_in = clk_ff;
         last_comm_in  = comm_ff;
         tick_in       = 32'd0;
      end

      if (cmd.avg_a_wr) begin
         avgs_in[ia] = avg_a_val;
      end
      if (cmd.avg_b_wr) begin
         avgs_in[ib] = avg_b_val;
      end

      if (cmd.adv) begin
         unique case (phase_ff)
            afws_pkg::PH_SETTLE: begin
               for (int i = 0; i < 4; i++) begin
                  sums_in[i]   = 64'd0;
                  counts_in[i] = 32'd0;
               end
            end
            afws_pkg::PH_LOCAL:  part_in = 1'b0;
            afws_pkg::PH_REMOTE: part_in = sum_r > sum_l;
            default: ;
         endcase
         phase_in = phase_ff + 2'd1;
         tick_in  = 32'd0;
      end

      if (cmd.out_load) begin
         out_in = {phase_ff, part_ff, step_ff, window_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff         <= afws_pkg::DECISION_LENGTH_RST;
         rl_ff         <= afws_pkg::RECALC_LIMIT_RST;
         wmax_ff       <= afws_pkg::WINDOW_MAX_RST;
         window_ff     <= afws_pkg::WINDOW_RST;
         step_ff       <= afws_pkg::STEP_RST;
         tick_ff       <= '0;
         last_clock_ff <= '0;
         last_comm_ff  <= '0;
         last_rate_ff  <= '0;
         phase_ff      <= afws_pkg::PH_SETTLE;
         part_ff       <= 1'b1;
         for (int i = 0; i < 4; i++) begin
            sums_ff[i]   <= '0;
            counts_ff[i] <= '0;
            avgs_ff[i]   <= '0;
         end
      end else begin
         dl_ff         <= dl_in;
         rl_ff         <= rl_in;
         wmax_ff       <= wmax_in;
         window_ff     <= window_in;
         step_ff       <= step_in;
         tick_ff       <= tick_in;
         last_clock_ff <= last_clock_in;
         last_comm_ff  <= last_comm_in;
         last_rate_ff  <= last_rate_in;
         phase_ff      <= phase_in;
         part_ff       <= part_in;
         sums_ff       <= sums_in;
         counts_ff     <= counts_in;
         avgs_ff       <= avgs_in;
      end
   end

   always_ff @(posedge clock) begin
      clk_ff  <= clk_in;
      comm_ff <= comm_in;
      num_ff  <= num_in;
      dclk_ff <= dclk_in;
      out_ff  <= out_in;
   end

   assign rsp_tdata = {5'd0, out_ff};

   a_adv_clears_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.adv |=> tick_ff == 32'd0)
      else $error("tick count not cleared after phase advance");

   a_adv_steps_phase: assert property (@(posedge clock) disable iff (reset)
      cmd.adv |=> phase_ff == $past(phase_ff) + 2'd1)
      else $error("phase did not advance by one");

   a_window_floor: assert property (@(posedge clock) disable iff (reset)
      (cmd.rate_upd && last_rate_ff != 64'd0) |=> (window_ff != 8'd0 || step_ff == 8'hFF))
      else $error("empty window without shrinking step");

endmodule

`default_nettype wire

>>> sv/afws_ctrl.sv
// controller state machine sequencing each beat through the datapath
`default_nettype none

module afws_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic [1:0]               req_tuser,
   output      logic                     req_tready,
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire afws_pkg::dp_status_type  status,
   output      afws_pkg::dp_cmd_type     cmd
);

   afws_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic fire;
   logic slot_free;

   assign fire      = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         afws_pkg::S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == afws_pkg::CMD_TICK && status.recalc_go) begin
                  state_in = afws_pkg::S_RMUL;
               end else if (req_tuser == afws_pkg::CMD_TICK && status.adv_go) begin
                  state_in = afws_pkg::S_ADV;
               end else begin
                  state_in = afws_pkg::S_FINISH;
               end
            end
         end
         afws_pkg::S_RMUL:   state_in = afws_pkg::S_RSTART;
         afws_pkg::S_RSTART: state_in = afws_pkg::S_RDIV;
         afws_pkg::S_RDIV: begin
            if (status.div_done) state_in = afws_pkg::S_RUPD;
         end
         afws_pkg::S_RUPD:   state_in = afws_pkg::S_FINISH;
         afws_pkg::S_ADV: begin
            state_in = status.measure_phase ? afws_pkg::S_AVGA : afws_pkg::S_FINISH;
         end
         afws_pkg::S_AVGA: begin
            if (status.div_done) state_in = afws_pkg::S_AVGB;
         end
         afws_pkg::S_AVGB: begin
            if (status.div_done) state_in = afws_pkg::S_PART;
         end
         afws_pkg::S_PART:   state_in = afws_pkg::S_FINISH;
         afws_pkg::S_FINISH: begin
            if (slot_free) state_in = afws_pkg::S_IDLE;
         end
         default:            state_in = afws_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.div_sel  = afws_pkg::DIV_RATE;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         afws_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = fire;
         end
         afws_pkg::S_RMUL:   cmd.mul = 1'b1;
         afws_pkg::S_RSTART: cmd.div_start = 1'b1;
         afws_pkg::S_RDIV:   ;
         afws_pkg::S_RUPD:   cmd.rate_upd = 1'b1;
         afws_pkg::S_ADV: begin
            if (status.measure_phase) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = afws_pkg::DIV_AVG_A;
            end else begin
               cmd.adv = 1'b1;
            end
         end
         afws_pkg::S_AVGA: begin
            cmd.div_sel = afws_pkg::DIV_AVG_A;
            if (status.div_done) begin
               cmd.avg_a_wr  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = afws_pkg::DIV_AVG_B;
            end
         end
         afws_pkg::S_AVGB: begin
            cmd.div_sel  = afws_pkg::DIV_AVG_B;
            cmd.avg_b_wr = status.div_done;
         end
         afws_pkg::S_PART:   cmd.adv = 1'b1;
         afws_pkg::S_FINISH: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= afws_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> bench/afws_checker.sv
// checker for the fetch window scheduler: predicts each result beat and compares it
`default_nettype none

module afws_checker
   import afws_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [143:0] req_tdata,
   input  wire logic [1:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [23:0]  rsp_tdata,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data,
   output int                failures,
   output int                pending
);

   typedef struct packed {
      logic [1:0] phase;
      logic       part;
      logic [7:0] step;
      logic [7:0] win;
   } sched_out_type;

   sched_out_type expected_q[$];

   logic [31:0] decision_len;
   logic [31:0] recalc_lim;
   logic [7:0]  win_max;

   int          win;
   int          step;
   logic [31:0] ticks;
   logic [63:0] stamp_seen;
   logic [31:0] prev_commit;
   logic [63:0] prev_rate;
   phase_type   phase;
   logic        part;
   logic [63:0] sums[4];
   logic [31:0] counts[4];
   logic [63:0] avgs[4];

   function automatic logic [63:0] mean_of(int i);
      return (counts[i] != 0) ? sums[i] / {32'd0, counts[i]} : 64'd0;
   endfunction

   // hill climb on measured throughput
   task automatic update_window(logic [63:0] now, logic [31:0] commit);
      logic [31:0] dcommit;
      logic [63:0] dclk;
      logic [63:0] num;
      logic [63:0] rate;
      int          s;
      int          h;
      int          w;
      dcommit = commit - prev_commit;
      dclk    = now - stamp_seen;
      num     = ({32'd0, dcommit} * {44'd0, RATE_SCALE}) << RATE_FRAC_BITS_DEF;
      if (dclk == 0) rate = (num != 0) ? '1 : '0;
      else rate = num / dclk;
      s = step;
      if (prev_rate > 0) begin
         if (rate > prev_rate) begin
            s = s * 2;
            if (step >= 32 || step <= -32) s = s >>> 1;
         end else begin
            h = s >>> 1;
            if (s <= 4 && s >= -4) h = h * 2;
            s = -h;
         end
         w = win + s;
         if (w > 0) begin
            if (w > int'(win_max)) w = int'(win_max);
            win = w;
         end else begin
            win = 0;
            s = -1;
         end
         step = s;
      end
      prev_rate   = rate;
      stamp_seen  = now;
      prev_commit = commit;
      ticks       = 0;
   endtask

   task automatic advance_phase();
      logic [64:0] slow_side;
      logic [64:0] fast_side;
      case (phase)
         PH_SETTLE: begin
            for (int i = 0; i < 4; i++) begin
               sums[i]   = 0;
               counts[i] = 0;
            end
         end
         PH_LOCAL: begin
            avgs[0] = mean_of(0);
            avgs[2] = mean_of(2);
            part = 1'b0;
         end
         PH_REMOTE: begin
            avgs[1] = mean_of(1);
            avgs[3] = mean_of(3);
            // remote exec minus local exec against local fetch minus remote fetch
            slow_side = {1'b0, avgs[1]} + {1'b0, avgs[3]};
            fast_side = {1'b0, avgs[2]} + {1'b0, avgs[0]};
            part = slow_side > fast_side;
         end
         default: ;
      endcase
      phase = phase_type'(phase + 2'd1);
      ticks = 0;
   endtask

   task automatic predict_beat(logic [1:0] cmd, logic [143:0] data);
      sched_out_type e;
      logic [31:0]   old;
      int            idx;
      if (cmd == CMD_EXEC || cmd == CMD_FETCH) begin
         if (phase == PH_LOCAL || phase == PH_REMOTE) begin
            idx = ((phase == PH_LOCAL) ? 0 : 1) + ((cmd == CMD_FETCH) ? 2 : 0);
            sums[idx]   = sums[idx] + {16'd0, data[47:0]};
            counts[idx] = counts[idx] + 32'd1;
         end
      end else if (cmd == CMD_TICK) begin
         old   = ticks;
         ticks = old + 32'd1;
         if (old > recalc_lim) update_window(data[111:48], data[143:112]);
         if (ticks > decision_len) advance_phase();
      end
      e.win   = win[7:0];
      e.step  = step[7:0];
      e.part  = part;
      e.phase = phase;
      expected_q.push_back(e);
   endtask

   always @(posedge clock) begin
      sched_out_type e;
      sched_out_type got;
      if (reset) begin
         expected_q.delete();
         decision_len = DECISION_LENGTH_RST;
         recalc_lim   = RECALC_LIMIT_RST;
         win_max      = WINDOW_MAX_RST;
         win          = int'(WINDOW_RST);
         step         = int'(STEP_RST);
         ticks        = 0;
         stamp_seen   = 0;
         prev_commit  = 0;
         prev_rate    = 0;
         phase        = PH_SETTLE;
         part         = 1'b1;
         for (int i = 0; i < 4; i++) begin
            sums[i]   = 0;
            counts[i] = 0;
            avgs[i]   = 0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DECISION_LENGTH: decision_len = csr_data;
               CSR_RECALC_LIMIT:    recalc_lim   = csr_data;
               CSR_WINDOW_MAX:      win_max      = csr_data[7:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[18:0];
            if (expected_q.size() == 0) begin
               failures <= failures + 1;
               $display("%0t: unexpected result beat %h", $time, rsp_tdata);
            end else begin
               e = expected_q.pop_front();
               if (got.win !== e.win || got.step !== e.step || got.part !== e.part ||
                   got.phase !== e.phase) begin
                  failures <= failures + 1;
                  $display({"%0t: mismatch win/step/part/phase expected %0d/%0d/%0d/%0d",
                            " got %0d/%0d/%0d/%0d"},
                           $time, e.win, $signed(e.step), e.part, e.phase,
                           got.win, $signed(got.step), got.part, got.phase);
               end
            end
         end
         if (req_tvalid && req_tready) predict_beat(req_tuser, req_tdata);
      end
      pending <= expected_q.size();
   end

   initial begin
      failures = 0;
      pending  = 0;
   end

endmodule

`default_nettype wire

>>> bench/tb.sv
// top of the bench: clock, reset, stimulus, back pressure and verdict
`default_nettype none

module tb;
   import afws_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [23:0]  rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [31:0]  csr_data;
   int           failures;
   int           pending;
   int           cycles;
   logic         calm;
   logic [63:0]  now_ctr;
   logic [31:0]  commit_ctr;

   adaptive_fetch_window_scheduler dut (.*);

   afws_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // stretch with no idling on either side
   assign calm = cycles >= 8000 && cycles < 14000;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: random stalls plus one long hold-off so the block backs up
   initial begin
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (cycles == 3000) begin
            hold = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || $urandom_range(99) >= 16;
         end
      end
   end

   task automatic send_beat(logic [1:0] cmd, logic [47:0] dur, logic [63:0] now,
                            logic [31:0] commit);
      if (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {commit, now, dur};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic reconfigure(logic [31:0] dl, logic [31:0] rl, logic [7:0] wm);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_reg(CSR_DECISION_LENGTH, dl);
      write_reg(CSR_RECALC_LIMIT, rl);
      write_reg(CSR_WINDOW_MAX, wm);
      csr_valid <= 1'b0;
   endtask

   task automatic tick();
      int r;
      r = $urandom_range(99);
      if (r < 5) begin
         // same clock again
      end else if (r < 10) begin
         now_ctr    = {$urandom, $urandom};
         commit_ctr = $urandom;
      end else begin
         now_ctr    = now_ctr + $urandom_range(1, 5000);
         commit_ctr = commit_ctr + $urandom_range(0, 3000);
      end
      send_beat(CMD_TICK, {$urandom, $urandom}, now_ctr, commit_ctr);
   endtask

   task automatic random_items(int n, int tick_pct);
      logic [47:0] dur;
      int          r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         case ($urandom_range(3))
            0: dur = '0;
            1: dur = '1;
            2: dur = $urandom_range(1, 100000);
            default: dur = {$urandom, $urandom};
         endcase
         if (r < tick_pct) tick();
         else if (r < 95) send_beat(($urandom_range(1) != 0) ? CMD_FETCH : CMD_EXEC, dur,
                                    {$urandom, $urandom}, $urandom);
         else send_beat(CMD_UNUSED, dur, {$urandom, $urandom}, $urandom);
      end
   endtask

   initial begin
      cycles     = 0;
      now_ctr    = 0;
      commit_ctr = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_EXEC;
      csr_valid  = 1'b0;
      csr_index  = CSR_DECISION_LENGTH;
      csr_data   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: samples ignored in settle phase, unused command, a tick
      send_beat(CMD_EXEC, '0, '0, '0);
      send_beat(CMD_FETCH, '1, '1, '1);
      send_beat(CMD_UNUSED, '1, '1, '1);
      tick();

      // walk the four phases with extreme samples
      reconfigure(32'd1, 32'hFFFF_FFFF, 8'd255);
      tick(); tick();
      send_beat(CMD_EXEC, '1, '0, '0);
      send_beat(CMD_EXEC, '1, '0, '0);
      send_beat(CMD_FETCH, '0, '0, '0);
      tick(); tick();
      send_beat(CMD_EXEC, 48'd1, '0, '0);
      send_beat(CMD_FETCH, '1, '0, '0);
      tick(); tick();
      send_beat(CMD_EXEC, '1, '0, '0);
      tick(); tick();

      // window recalculation with zero clock difference and extremes
      reconfigure(32'hFFFF_FFFF, 32'd1, 8'd1);
      for (int i = 0; i < 6; i++) begin
         commit_ctr = commit_ctr + 32'd7;
         send_beat(CMD_TICK, '0, now_ctr, commit_ctr);
      end

      reconfigure(32'd3, 32'hFFFF_FFFF, 8'd200);
      random_items(200, 25);
      reconfigure(32'hFFFF_FFFF, 32'd1, 8'd255);
      random_items(160, 75);
      reconfigure(32'hFFFF_FFFF, 32'd2, 8'd1);
      random_items(100, 75);
      reconfigure(32'hFFFF_FFFF, 32'd1, 8'($urandom_range(1, 255)));
      random_items(120, 75);
      reconfigure(32'($urandom_range(2, 6)), 32'hFFFF_FFFF, 8'd40);
      random_items(150, 25);
      reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd128);
      random_items(90, 50);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (140) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
